[design/shgl_pkg.sv]
`timescale 1ns / 1ps

package shgl_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int RES_BITS   = 16;
  localparam int INDEX_BITS = 24;

  localparam int AXES       = 3;
  localparam int COORD_W    = 32;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int PROD_W     = 2 * COORD_W;
  localparam int SHIFT      = 2 * FRAC_BITS;
  localparam int Q_W        = PROD_W - SHIFT;
  localparam int HASH_W     = 32;
  localparam int WIDE_W     = 64;
  localparam int MOD_W      = INDEX_BITS + 1;
  localparam int RES_FIELD_W = 3 * RES_BITS;
  localparam int HSIZE_W    = 25;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [HASH_W-1:0] PRIME [AXES] = '{32'd73856093, 32'd19349663, 32'd83492791};

  localparam logic [MOD_W-1:0] MOD_LIMIT = MOD_W'(1) << INDEX_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_X     = 3'd0,
    REG_MIN_Y     = 3'd1,
    REG_MIN_Z     = 3'd2,
    REG_SCALE_X   = 3'd3,
    REG_SCALE_Y   = 3'd4,
    REG_SCALE_Z   = 3'd5,
    REG_GRID_RES  = 3'd6,
    REG_HASH_SIZE = 3'd7
  } cfg_reg_t;

  // What travels down the modulo pipeline alongside the running remainder.
  typedef struct packed {
    logic                           hit;
    logic [AXES-1:0][RES_BITS-1:0]  cells;
    logic [HASH_W-1:0]              h;
  } carry_t;

endpackage

[design/spatial_hash_grid_lookup.sv]
`timescale 1ns / 1ps

// Spatial hash grid lookup.
// A query point (three signed Q16.16 coordinates) is offered on the in_ channel and the
// word is taken when in_valid and in_ready are both high. For each point one result
// word appears on the out_ channel: the in-bounds flag, the three clamped cell
// coordinates and the hash bucket index (zero when out of bounds or the hash size is 0).
// Grid minimum, scale, resolution and hash size are written through the cfg_ port,
// one register per cycle with cfg_we high; write them only while no word is in flight.
// The path from acceptance to out_valid runs through seven stages of offset, multiply,
// clamp and hash, then 64 stages of the bucket modulo (one remainder bit per stage,
// a 25-bit compare and subtract each), then the output register.
// Throughput is one word per cycle while the receiver takes words.
// When the receiver holds out_ready low with a word waiting, the whole pipeline
// freezes and in_ready drops; nothing is lost or repeated.
// Reset (rst_n low at a clock edge) empties the pipeline and loads the registers with
// minimum 0, scale 1.0, a one-cell grid on every axis and a hash size of 1.

module spatial_hash_grid_lookup (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [shgl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [shgl_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [shgl_pkg::COORD_W-1:0]  in_point_x,
  input  logic signed [shgl_pkg::COORD_W-1:0]  in_point_y,
  input  logic signed [shgl_pkg::COORD_W-1:0]  in_point_z,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_in_bounds,
  output logic [shgl_pkg::RES_BITS-1:0]        out_cell_x,
  output logic [shgl_pkg::RES_BITS-1:0]        out_cell_y,
  output logic [shgl_pkg::RES_BITS-1:0]        out_cell_z,
  output logic [shgl_pkg::INDEX_BITS-1:0]      out_bucket_index
);
  import shgl_pkg::*;

  localparam int DSTEPS = WIDE_W;

  // Configuration registers
  logic [COORD_W-1:0]     min_r   [AXES];
  logic [COORD_W-1:0]     scale_r [AXES];
  logic [RES_FIELD_W-1:0] grid_res_r;
  logic [HSIZE_W-1:0]     hash_size_r;
  logic [MOD_W-1:0]       modulus;
  logic                   mod_zero;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < AXES; a++) begin
        min_r[a]   <= '0;
        scale_r[a] <= COORD_W'(1) << FRAC_BITS;
      end
      grid_res_r  <= {RES_BITS'(1), RES_BITS'(1), RES_BITS'(1)};
      hash_size_r <= HSIZE_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MIN_X:     min_r[0]    <= cfg_wdata[COORD_W-1:0];
        REG_MIN_Y:     min_r[1]    <= cfg_wdata[COORD_W-1:0];
        REG_MIN_Z:     min_r[2]    <= cfg_wdata[COORD_W-1:0];
        REG_SCALE_X:   scale_r[0]  <= cfg_wdata[COORD_W-1:0];
        REG_SCALE_Y:   scale_r[1]  <= cfg_wdata[COORD_W-1:0];
        REG_SCALE_Z:   scale_r[2]  <= cfg_wdata[COORD_W-1:0];
        REG_GRID_RES:  grid_res_r  <= cfg_wdata[RES_FIELD_W-1:0];
        REG_HASH_SIZE: hash_size_r <= cfg_wdata[HSIZE_W-1:0];
      endcase
    end
  end

  // A hash size above the index range saturates to it.
  always_comb begin
    if (MOD_W'(hash_size_r) > MOD_LIMIT) begin
      modulus = MOD_LIMIT;
    end else begin
      modulus = MOD_W'(hash_size_r);
    end
    mod_zero = (modulus == '0);
  end

  // Pipeline advance: everything moves unless a result waits on a stalled receiver.
  logic out_valid_r;
  logic en;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  logic [COORD_W-1:0] point [AXES];
  assign point[0] = in_point_x;
  assign point[1] = in_point_y;
  assign point[2] = in_point_z;

  // Valid bits of the front stages
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  // Per-axis front end: offset, magnitude, multiply, truncate, range check, prime product
  logic [DIFF_W-1:0]    diff1_r  [AXES];
  logic [DIFF_W-1:0]    mag2_r   [AXES];
  logic                 neg2_r   [AXES];
  logic [PROD_W-1:0]    plo3_r   [AXES];
  logic                 top3_r   [AXES];
  logic                 neg3_r   [AXES];
  logic [Q_W-1:0]       q4_r     [AXES];
  logic                 neg4_r   [AXES];
  logic [RES_BITS-1:0]  cell5_r  [AXES];
  logic                 ok5_r    [AXES];
  logic [HASH_W-1:0]    prod6_r  [AXES];
  logic [RES_BITS-1:0]  cell6_r  [AXES];
  logic [RES_BITS-1:0]  cell7_r  [AXES];

  for (genvar a = 0; a < AXES; a++) begin : g_axis
    logic [DIFF_W-1:0]   diff1_nxt;
    logic [DIFF_W-1:0]   mag2_nxt;
    logic [PROD_W-1:0]   full4;
    logic [RES_BITS-1:0] res;
    logic [RES_BITS-1:0] cell5_nxt;
    logic                ok5_nxt;

    assign diff1_nxt = {point[a][COORD_W-1], point[a]} - {min_r[a][COORD_W-1], min_r[a]};
    assign mag2_nxt  = diff1_r[a][DIFF_W-1] ? (~diff1_r[a] + DIFF_W'(1)) : diff1_r[a];
    // The magnitude's top bit, if set, adds the scale one word higher.
    assign full4     = plo3_r[a] + (top3_r[a] ? {scale_r[a], COORD_W'(0)} : PROD_W'(0));
    assign res       = grid_res_r[a*RES_BITS +: RES_BITS];

    always_comb begin
      if (res == '0) begin
        cell5_nxt = '0;
        ok5_nxt   = 1'b0;
      end else if (neg4_r[a] && (q4_r[a] != '0)) begin
        cell5_nxt = '0;
        ok5_nxt   = 1'b0;
      end else if (q4_r[a] >= Q_W'(res)) begin
        cell5_nxt = res - RES_BITS'(1);
        ok5_nxt   = 1'b0;
      end else begin
        cell5_nxt = q4_r[a][RES_BITS-1:0];
        ok5_nxt   = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        diff1_r[a] <= diff1_nxt;
        mag2_r[a]  <= mag2_nxt;
        neg2_r[a]  <= diff1_r[a][DIFF_W-1];
        plo3_r[a]  <= PROD_W'(mag2_r[a][COORD_W-1:0]) * PROD_W'(scale_r[a]);
        top3_r[a]  <= mag2_r[a][COORD_W];
        neg3_r[a]  <= neg2_r[a];
        q4_r[a]    <= full4[PROD_W-1:SHIFT];
        neg4_r[a]  <= neg3_r[a];
        cell5_r[a] <= cell5_nxt;
        ok5_r[a]   <= ok5_nxt;
        prod6_r[a] <= HASH_W'(cell5_r[a]) * PRIME[a];
        cell6_r[a] <= cell5_r[a];
        cell7_r[a] <= cell6_r[a];
      end
    end
  end

  logic              hit6_r;
  logic              hit7_r;
  logic [HASH_W-1:0] h7_r;

  always_ff @(posedge clk) begin
    if (en) begin
      hit6_r <= ok5_r[0] && ok5_r[1] && ok5_r[2];
      hit7_r <= hit6_r;
      h7_r   <= prod6_r[0] ^ prod6_r[1] ^ prod6_r[2];
    end
  end

  // Bucket modulo: restoring remainder over the sign-extended 64-bit hash word,
  // most significant bit first, one bit per stage.
  logic               dv_r   [DSTEPS+1];
  carry_t             dc_r   [DSTEPS+1];
  logic [MOD_W-1:0]   rem_r  [DSTEPS+1];

  assign dv_r[0] = v7_r;
  assign dc_r[0] = '{hit: hit7_r, cells: {cell7_r[2], cell7_r[1], cell7_r[0]}, h: h7_r};
  assign rem_r[0] = '0;

  for (genvar k = 0; k < DSTEPS; k++) begin : g_div
    localparam int BIT = WIDE_W - 1 - k;
    localparam int SRC = (BIT >= HASH_W) ? HASH_W - 1 : BIT;
    logic [MOD_W-1:0] trial;
    logic [MOD_W-1:0] rem_nxt;

    assign trial   = {rem_r[k][MOD_W-2:0], dc_r[k].h[SRC]};
    assign rem_nxt = (trial >= modulus) ? (trial - modulus) : trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k+1] <= 1'b0;
      end else if (en) begin
        dv_r[k+1] <= dv_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dc_r[k+1]  <= dc_r[k];
        rem_r[k+1] <= rem_nxt;
      end
    end
  end

  // Output register
  carry_t                last;
  logic                  in_bounds_r;
  logic [RES_BITS-1:0]   cell_x_r, cell_y_r, cell_z_r;
  logic [INDEX_BITS-1:0] bucket_r;
  logic [INDEX_BITS-1:0] bucket_nxt;

  assign last       = dc_r[DSTEPS];
  assign bucket_nxt = (last.hit && !mod_zero) ? rem_r[DSTEPS][INDEX_BITS-1:0] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_r[DSTEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_bounds_r <= last.hit;
      cell_x_r    <= last.cells[0];
      cell_y_r    <= last.cells[1];
      cell_z_r    <= last.cells[2];
      bucket_r    <= bucket_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_in_bounds    = in_bounds_r;
  assign out_cell_x       = cell_x_r;
  assign out_cell_y       = cell_y_r;
  assign out_cell_z       = cell_z_r;
  assign out_bucket_index = bucket_r;

endmodule

[test/shgl_bucket_monitor.sv]
`timescale 1ns / 1ps

module shgl_bucket_monitor (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [shgl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [shgl_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic [shgl_pkg::COORD_W-1:0]     in_point_x,
  input  logic [shgl_pkg::COORD_W-1:0]     in_point_y,
  input  logic [shgl_pkg::COORD_W-1:0]     in_point_z,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic                             out_in_bounds,
  input  logic [shgl_pkg::RES_BITS-1:0]    out_cell_x,
  input  logic [shgl_pkg::RES_BITS-1:0]    out_cell_y,
  input  logic [shgl_pkg::RES_BITS-1:0]    out_cell_z,
  input  logic [shgl_pkg::INDEX_BITS-1:0]  out_bucket_index,
  output int                               fail_count,
  output int                               pending,
  output int                               lookups_seen,
  output int                               hits_seen
);
  import shgl_pkg::*;

  localparam logic [31:0] MUL_X = 32'd73856093;
  localparam logic [31:0] MUL_Y = 32'd19349663;
  localparam logic [31:0] MUL_Z = 32'd83492791;
  localparam logic [24:0] BUCKET_CAP = 25'h100_0000;

  typedef struct packed {
    logic                  in_bounds;
    logic [RES_BITS-1:0]   cell_x;
    logic [RES_BITS-1:0]   cell_y;
    logic [RES_BITS-1:0]   cell_z;
    logic [INDEX_BITS-1:0] bucket;
  } lookup_t;

  logic [31:0] grid_min [3];
  logic [31:0] grid_scale [3];
  logic [47:0] grid_cells;
  logic [24:0] n_buckets;

  lookup_t expected_q [$];
  lookup_t got;
  int errors = 0;
  int lookups = 0;
  int hits = 0;

  // The cell is the magnitude of the offset times the scale, truncated, with the
  // sign put back afterwards; anything outside 0..res-1 clamps to the nearer end.
  function automatic logic place_on_axis(input logic [31:0] pt, input logic [31:0] mn,
                                         input logic [31:0] scl, input logic [15:0] res,
                                         output logic [15:0] cell_out);
    logic signed [33:0] diff;
    logic [32:0] mag;
    logic [63:0] prod;
    logic [31:0] q;
    logic neg;
    diff = $signed({{2{pt[31]}}, pt}) - $signed({{2{mn[31]}}, mn});
    neg = diff[33];
    mag = neg ? 33'(-diff) : 33'(diff);
    prod = 64'(mag) * 64'(scl);
    q = prod[63:32];
    if (res == 0) begin
      cell_out = '0;
      return 1'b0;
    end
    if (neg && q != 0) begin
      cell_out = '0;
      return 1'b0;
    end
    if (q >= {16'b0, res}) begin
      cell_out = res - 16'd1;
      return 1'b0;
    end
    cell_out = q[15:0];
    return 1'b1;
  endfunction

  function automatic lookup_t predict_lookup(input logic [31:0] px, input logic [31:0] py,
                                             input logic [31:0] pz);
    lookup_t r;
    logic bx, by, bz;
    logic [31:0] h;
    logic [63:0] wide;
    logic [24:0] modulus;
    bx = place_on_axis(px, grid_min[0], grid_scale[0], grid_cells[15:0], r.cell_x);
    by = place_on_axis(py, grid_min[1], grid_scale[1], grid_cells[31:16], r.cell_y);
    bz = place_on_axis(pz, grid_min[2], grid_scale[2], grid_cells[47:32], r.cell_z);
    r.in_bounds = bx & by & bz;
    r.bucket = '0;
    if (r.in_bounds) begin
      h = ({16'b0, r.cell_x} * MUL_X) ^ ({16'b0, r.cell_y} * MUL_Y)
        ^ ({16'b0, r.cell_z} * MUL_Z);
      wide = {{32{h[31]}}, h};
      modulus = (n_buckets > BUCKET_CAP) ? BUCKET_CAP : n_buckets;
      if (modulus != 0)
        r.bucket = INDEX_BITS'(wide % {39'b0, modulus});
    end
    return r;
  endfunction

  task automatic note_field(input string name, input logic [31:0] exp_v,
                            input logic [31:0] got_v);
    errors++;
    $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, got_v);
  endtask

  task automatic compare_lookup(input lookup_t exp_w, input lookup_t got_w);
    if (got_w.in_bounds !== exp_w.in_bounds)
      note_field("in_bounds", 32'(exp_w.in_bounds), 32'(got_w.in_bounds));
    if (got_w.cell_x !== exp_w.cell_x)
      note_field("cell_x", 32'(exp_w.cell_x), 32'(got_w.cell_x));
    if (got_w.cell_y !== exp_w.cell_y)
      note_field("cell_y", 32'(exp_w.cell_y), 32'(got_w.cell_y));
    if (got_w.cell_z !== exp_w.cell_z)
      note_field("cell_z", 32'(exp_w.cell_z), 32'(got_w.cell_z));
    if (got_w.bucket !== exp_w.bucket)
      note_field("bucket_index", 32'(exp_w.bucket), 32'(got_w.bucket));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      grid_min[0] <= '0;
      grid_min[1] <= '0;
      grid_min[2] <= '0;
      grid_scale[0] <= 32'h0001_0000;
      grid_scale[1] <= 32'h0001_0000;
      grid_scale[2] <= 32'h0001_0000;
      grid_cells <= 48'h0001_0001_0001;
      n_buckets <= 25'd1;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MIN_X:     grid_min[0] <= cfg_wdata[31:0];
          REG_MIN_Y:     grid_min[1] <= cfg_wdata[31:0];
          REG_MIN_Z:     grid_min[2] <= cfg_wdata[31:0];
          REG_SCALE_X:   grid_scale[0] <= cfg_wdata[31:0];
          REG_SCALE_Y:   grid_scale[1] <= cfg_wdata[31:0];
          REG_SCALE_Z:   grid_scale[2] <= cfg_wdata[31:0];
          REG_GRID_RES:  grid_cells <= cfg_wdata[47:0];
          REG_HASH_SIZE: n_buckets <= cfg_wdata[24:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_q.insert(expected_q.size(),
                          predict_lookup(in_point_x, in_point_y, in_point_z));
      if (out_valid && out_ready) begin
        got = {out_in_bounds, out_cell_x, out_cell_y, out_cell_z, out_bucket_index};
        lookups++;
        if (out_in_bounds)
          hits++;
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: result word with nothing expected, expected none, got %h",
                   $time, got);
        end else begin
          compare_lookup(expected_q.pop_front(), got);
        end
      end
    end
    fail_count <= errors;
    pending <= expected_q.size();
    lookups_seen <= lookups;
    hits_seen <= hits;
  end

endmodule

[test/spatial_hash_grid_lookup_tb.sv]
`timescale 1ns / 1ps

module spatial_hash_grid_lookup_tb;
  import shgl_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic [COORD_W-1:0]    in_point_x;
  logic [COORD_W-1:0]    in_point_y;
  logic [COORD_W-1:0]    in_point_z;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_in_bounds;
  logic [RES_BITS-1:0]   out_cell_x;
  logic [RES_BITS-1:0]   out_cell_y;
  logic [RES_BITS-1:0]   out_cell_z;
  logic [INDEX_BITS-1:0] out_bucket_index;

  int fail_count;
  int pending;
  int lookups_seen;
  int hits_seen;

  int points_sent = 0;
  int grid_settings = 0;
  int idle_pct = 0;
  bit calm = 1'b0;
  bit long_hold_done = 1'b0;

  // Current grid, kept here only to aim the random points at the cells.
  logic [31:0] cur_min [3];
  logic [31:0] cur_scale [3];
  logic [15:0] cur_res [3];

  always #4 clk = ~clk;

  spatial_hash_grid_lookup dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_point_x       (in_point_x),
    .in_point_y       (in_point_y),
    .in_point_z       (in_point_z),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_in_bounds    (out_in_bounds),
    .out_cell_x       (out_cell_x),
    .out_cell_y       (out_cell_y),
    .out_cell_z       (out_cell_z),
    .out_bucket_index (out_bucket_index)
  );

  shgl_bucket_monitor bucket_mon (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_point_x       (in_point_x),
    .in_point_y       (in_point_y),
    .in_point_z       (in_point_z),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_in_bounds    (out_in_bounds),
    .out_cell_x       (out_cell_x),
    .out_cell_y       (out_cell_y),
    .out_cell_z       (out_cell_z),
    .out_bucket_index (out_bucket_index),
    .fail_count       (fail_count),
    .pending          (pending),
    .lookups_seen     (lookups_seen),
    .hits_seen        (hits_seen)
  );

  // Bits above the register's width are filled with noise; the block must ignore them.
  task automatic write_reg(input cfg_reg_t idx, input logic [47:0] value, input int width);
    logic [63:0] noise;
    logic [47:0] junk;
    noise = {$urandom, $urandom};
    junk = noise[47:0];
    junk = (width < 48) ? (junk << width) : '0;
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value | junk;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_grid(input logic [31:0] mx, input logic [31:0] my, input logic [31:0] mz,
                          input logic [31:0] sx, input logic [31:0] sy, input logic [31:0] sz,
                          input logic [15:0] rx, input logic [15:0] ry, input logic [15:0] rz,
                          input logic [24:0] buckets);
    wait_idle();
    write_reg(REG_MIN_X, {16'b0, mx}, 32);
    write_reg(REG_MIN_Y, {16'b0, my}, 32);
    write_reg(REG_MIN_Z, {16'b0, mz}, 32);
    write_reg(REG_SCALE_X, {16'b0, sx}, 32);
    write_reg(REG_SCALE_Y, {16'b0, sy}, 32);
    write_reg(REG_SCALE_Z, {16'b0, sz}, 32);
    write_reg(REG_GRID_RES, {rz, ry, rx}, 48);
    write_reg(REG_HASH_SIZE, {23'b0, buckets}, 25);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_min = '{mx, my, mz};
    cur_scale = '{sx, sy, sz};
    cur_res = '{rx, ry, rz};
    grid_settings++;
  endtask

  task automatic random_grid();
    set_grid($urandom, $urandom, $urandom,
             $urandom_range(32'h800, 32'h40_0000), $urandom_range(32'h800, 32'h40_0000),
             $urandom_range(32'h800, 32'h40_0000),
             16'($urandom_range(1, 300)), 16'($urandom_range(1, 300)),
             16'($urandom_range(1, 300)), 25'($urandom_range(1, 32'h100_0000)));
  endtask

  task automatic offer(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_point_x <= x;
    in_point_y <= y;
    in_point_z <= z;
    do @(posedge clk); while (!in_ready);
    points_sent++;
  endtask

  // Mostly points spread over the grid and a little past its edges, some right at
  // the minimum, and some anywhere at all.
  function automatic logic [31:0] pick_coord(input int axis);
    logic [63:0] span;
    logic [63:0] off;
    if (cur_res[axis] == 0)
      span = 64'h10_0000;
    else if (cur_scale[axis] == 0)
      span = 64'h1_0000_0000;
    else
      span = ({48'b0, cur_res[axis]} << 32) / {32'b0, cur_scale[axis]};
    if (span > 64'h2_0000_0000)
      span = 64'h2_0000_0000;
    if (span == 0)
      span = 64'd1;
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2: return cur_min[axis] + 32'($urandom_range(0, 6)) - 32'd3;
      default: begin
        off = ({$urandom, $urandom} % (span + span / 8 + 1)) - span / 16;
        return cur_min[axis] + off[31:0];
      end
    endcase
  endfunction

  task automatic run_phase(input int n, input int pct);
    idle_pct = pct;
    repeat (n) offer(pick_coord(0), pick_coord(1), pick_coord(2));
  endtask

  initial begin
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      if (!long_hold_done && points_sent >= 60) begin
        // Long hold so that the pipeline fills and the input is pushed back.
        long_hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (!calm && $urandom_range(0, 99) < 25) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  end

  initial begin
    #8_000_000;
    $display("%0t: timed out with %0d results outstanding", $time, pending);
    $display("status: fail");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_MIN_X;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_point_x = '0;
    in_point_y = '0;
    in_point_z = '0;
    cur_min = '{32'h0, 32'h0, 32'h0};
    cur_scale = '{32'h1_0000, 32'h1_0000, 32'h1_0000};
    cur_res = '{16'd1, 16'd1, 16'd1};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset grid: one cell per axis, unit scale, a single bucket.
    idle_pct = 20;
    offer(32'h0, 32'h0, 32'h0);
    offer(32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF);
    offer(32'h0001_0000, 32'h0, 32'h0);
    offer(32'hFFFF_FFFF, 32'hFFFF_0001, 32'h0);
    offer(32'hFFFF_0000, 32'h0, 32'h0);

    set_grid(32'hFFFE_0000, 32'h0, 32'h0005_8000, 32'h0002_0000, 32'h0001_0000,
             32'h0000_8000, 16'd8, 16'd4, 16'd3, 25'd1000);
    offer(32'hFFFE_0000, 32'h0, 32'h0005_8000);
    offer(32'h0001_C000, 32'h0003_0000, 32'h000A_0000);
    offer(32'h0002_0000, 32'h0003_0000, 32'h000A_0000);
    offer(32'hFFFD_C000, 32'hFFFF_8000, 32'h0005_0000);
    offer(32'h0, 32'h0002_0000, 32'h0008_0000);
    offer(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    offer(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    offer(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);

    // No buckets at all, and a zero scale that pins z to cell 0.
    set_grid(32'h0, 32'h0, 32'h0, 32'h1_0000, 32'h1_0000, 32'h0,
             16'd4, 16'd2, 16'd2, 25'd0);
    offer(32'h0003_0000, 32'h0001_0000, 32'h7FFF_FFFF);
    offer(32'h0002_0000, 32'h0, 32'h0);

    set_grid(32'h0, 32'h0, 32'h0, 32'h1_0000, 32'h1_0000, 32'h1_0000,
             16'd4, 16'd0, 16'd2, 25'd77);
    offer(32'h0, 32'h0, 32'h0);

    // Widest grid, largest scale and a bucket count beyond the index range.
    set_grid(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
             32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 25'h1FF_FFFF);
    offer(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    offer(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    offer(32'h8000_0100, 32'h8000_0200, 32'h8000_0300);

    set_grid(32'h0, 32'h0, 32'h0, 32'h1_0000, 32'h1_0000, 32'h1_0000,
             16'd16, 16'd16, 16'd16, 25'd4096);
    run_phase(200, 30);
    set_grid(32'hFFFC_C000, 32'h0001_2345, 32'hFFFF_0000, 32'h0004_0000, 32'h0000_8000,
             32'h0001_2345, 16'd100, 16'd37, 16'd255, 25'd1000003);
    run_phase(200, 10);
    set_grid(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
             32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 25'h1FF_FFFF);
    run_phase(200, 30);
    set_grid(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1, 32'd1, 32'd1,
             16'd1, 16'd1, 16'd1, 25'h100_0000);
    run_phase(150, 0);
    set_grid($urandom, $urandom, $urandom, 32'h1_0000, 32'h0, 32'h2_0000,
             16'd5, 16'd3, 16'd9, 25'd0);
    run_phase(150, 30);
    random_grid();
    run_phase(200, 20);
    random_grid();
    run_phase(200, 20);
    set_grid(32'h0, 32'h0, 32'h0, 32'h1_0000, 32'h1_0000, 32'h1_0000,
             16'hFFFF, 16'd0, 16'd2, 25'd7);
    run_phase(100, 20);
    random_grid();
    calm = 1'b1;
    run_phase(200, 0);

    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (80) @(posedge clk);

    $display("%0d points sent under %0d grid settings; %0d lookups checked, %0d in bounds",
             points_sent, grid_settings, lookups_seen, hits_seen);
    if (pending != 0)
      $display("%0t: %0d expected results never arrived", $time, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
